// File: hw/rtl/yqr_pkg.sv
// Shared types and BT.601 integer coefficients for the 4:2:0 quad to RGB converter.
package yqr_pkg;

    localparam int PIX_W  = 8;
    localparam int PROD_W = 18;
    localparam int SUM_W  = 20;

    localparam int signed COEF_Y     = 298;
    localparam int signed COEF_RV    = 409;
    localparam int signed COEF_GU    = 100;
    localparam int signed COEF_GV    = 208;
    localparam int signed COEF_BU    = 516;
    localparam int signed LUMA_OFS   = 16;
    localparam int signed CHROMA_OFS = 128;
    localparam int signed RGB_RND    = 128;
    localparam int signed INTERP_RND = 8;

    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } t_yuv;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_rgb;

endpackage

// File: hw/rtl/yuv420_quad_to_rgb.sv
// Top level: 4:2:0 luma quad plus chroma rows to four clamped RGB pixels.
// One quad is accepted per clock while o_stall is low; its twelve color bytes pass
// through one register after the two chroma interpolators, one after the product
// stage of the four pixel lanes, and the output register that gathers the lanes.
// Each stage advances on its own when the next one is empty or moving, so empty
// slots close up and the input keeps taking transactions while an earlier result
// waits; o_stall rises only when all three stages hold data and i_stall is high.
module yuv420_quad_to_rgb (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [yqr_pkg::PIX_W-1:0] i_luma_top_left,
    input  logic [yqr_pkg::PIX_W-1:0] i_luma_top_right,
    input  logic [yqr_pkg::PIX_W-1:0] i_luma_bottom_left,
    input  logic [yqr_pkg::PIX_W-1:0] i_luma_bottom_right,
    input  logic [yqr_pkg::PIX_W-1:0] i_cb_prev_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cb_curr_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cb_next_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cb_post_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cr_prev_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cr_curr_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cr_next_row,
    input  logic [yqr_pkg::PIX_W-1:0] i_cr_post_row,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [yqr_pkg::PIX_W-1:0] o_red_top_left,
    output logic [yqr_pkg::PIX_W-1:0] o_green_top_left,
    output logic [yqr_pkg::PIX_W-1:0] o_blue_top_left,
    output logic [yqr_pkg::PIX_W-1:0] o_red_top_right,
    output logic [yqr_pkg::PIX_W-1:0] o_green_top_right,
    output logic [yqr_pkg::PIX_W-1:0] o_blue_top_right,
    output logic [yqr_pkg::PIX_W-1:0] o_red_bottom_left,
    output logic [yqr_pkg::PIX_W-1:0] o_green_bottom_left,
    output logic [yqr_pkg::PIX_W-1:0] o_blue_bottom_left,
    output logic [yqr_pkg::PIX_W-1:0] o_red_bottom_right,
    output logic [yqr_pkg::PIX_W-1:0] o_green_bottom_right,
    output logic [yqr_pkg::PIX_W-1:0] o_blue_bottom_right
);
    import yqr_pkg::*;

    localparam int LANES = 4;

    logic             w_en1, w_en2, w_en3;
    logic             r_v1, r_v2, r_v3;
    logic [PIX_W-1:0] w_u_bot, w_v_bot;
    t_yuv             n_pix [LANES];
    t_yuv             r_pix [LANES];
    t_rgb             w_rgb [LANES];
    t_rgb             r_rgb [LANES];

    assign w_en3   = !r_v3 || !i_stall;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    yqr_interp u_interp_cb (
        .i_prev   (i_cb_prev_row),
        .i_curr   (i_cb_curr_row),
        .i_next   (i_cb_next_row),
        .i_post   (i_cb_post_row),
        .o_chroma (w_u_bot)
    );

    yqr_interp u_interp_cr (
        .i_prev   (i_cr_prev_row),
        .i_curr   (i_cr_curr_row),
        .i_next   (i_cr_next_row),
        .i_post   (i_cr_post_row),
        .o_chroma (w_v_bot)
    );

    // The top row takes the current chroma sample, the bottom row the interpolated one.
    assign n_pix[0] = '{y: i_luma_top_left,     u: i_cb_curr_row, v: i_cr_curr_row};
    assign n_pix[1] = '{y: i_luma_top_right,    u: i_cb_curr_row, v: i_cr_curr_row};
    assign n_pix[2] = '{y: i_luma_bottom_left,  u: w_u_bot,       v: w_v_bot};
    assign n_pix[3] = '{y: i_luma_bottom_right, u: w_u_bot,       v: w_v_bot};

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_pix <= n_pix;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        yqr_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en2),
            .i_pix (r_pix[g]),
            .o_rgb (w_rgb[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_rgb <= w_rgb;
        end
    end

    assign o_red_top_left       = r_rgb[0].r;
    assign o_green_top_left     = r_rgb[0].g;
    assign o_blue_top_left      = r_rgb[0].b;
    assign o_red_top_right      = r_rgb[1].r;
    assign o_green_top_right    = r_rgb[1].g;
    assign o_blue_top_right     = r_rgb[1].b;
    assign o_red_bottom_left    = r_rgb[2].r;
    assign o_green_bottom_left  = r_rgb[2].g;
    assign o_blue_bottom_left   = r_rgb[2].b;
    assign o_red_bottom_right   = r_rgb[3].r;
    assign o_green_bottom_right = r_rgb[3].g;
    assign o_blue_bottom_right  = r_rgb[3].b;

    // The input is held off only when every stage is occupied.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled while a pipeline stage was empty");

    // A transaction in the product stage moves into an empty output register.
    a_fill_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_v3) |=> r_v3)
        else $error("product stage did not advance into an empty output register");

    // A taken result with nothing behind it leaves the output empty.
    a_drain_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_stall && !r_v2) |=> !r_v3)
        else $error("output transaction repeated after it was taken");

endmodule

// File: hw/rtl/yqr_interp.sv
// Vertical 4-tap chroma interpolator (-1,9,9,-1)/16 with rounding and clamping.
module yqr_interp (
    input  logic [yqr_pkg::PIX_W-1:0] i_prev,
    input  logic [yqr_pkg::PIX_W-1:0] i_curr,
    input  logic [yqr_pkg::PIX_W-1:0] i_next,
    input  logic [yqr_pkg::PIX_W-1:0] i_post,
    output logic [yqr_pkg::PIX_W-1:0] o_chroma
);
    import yqr_pkg::*;

    logic        [8:0]  w_sum_cn;
    logic        [8:0]  w_sum_pq;
    logic        [12:0] w_nine;
    logic signed [14:0] w_acc;
    logic signed [14:0] w_quot;

    assign w_sum_cn = {1'b0, i_curr} + {1'b0, i_next};
    assign w_sum_pq = {1'b0, i_prev} + {1'b0, i_post};
    // Nine times the inner pair as shift and add.
    assign w_nine   = {1'b0, w_sum_cn, 3'b000} + {4'b0000, w_sum_cn};
    assign w_acc    = $signed({2'b00, w_nine}) - $signed({6'b000000, w_sum_pq})
                    + 15'(INTERP_RND);
    assign w_quot   = w_acc >>> 4;

    always_comb begin
        if (w_quot[14]) begin
            o_chroma = '0;
        end else if (|w_quot[13:8]) begin
            o_chroma = '1;
        end else begin
            o_chroma = w_quot[7:0];
        end
    end

endmodule

// File: hw/rtl/yqr_lane.sv
// One pixel lane: BT.601 products in a register, then sums, shift and clamp.
module yqr_lane (
    input  logic          i_clk,
    input  logic          i_en,
    input  yqr_pkg::t_yuv i_pix,
    output yqr_pkg::t_rgb o_rgb
);
    import yqr_pkg::*;

    logic signed [8:0]        w_y;
    logic signed [8:0]        w_d;
    logic signed [8:0]        w_e;
    logic signed [PROD_W-1:0] n_c, n_rv, n_gu, n_gv, n_bu;
    logic signed [PROD_W-1:0] r_c, r_rv, r_gu, r_gv, r_bu;
    logic signed [SUM_W-1:0]  w_r, w_g, w_b;

    function automatic logic [PIX_W-1:0] clamp_shift8(input logic signed [SUM_W-1:0] v);
        logic [PIX_W-1:0] res;
        if (v[SUM_W-1]) begin
            res = '0;
        end else if (|v[SUM_W-2:16]) begin
            res = '1;
        end else begin
            res = v[15:8];
        end
        return res;
    endfunction

    assign w_y = $signed({1'b0, i_pix.y}) - 9'(LUMA_OFS);
    assign w_d = $signed({1'b0, i_pix.u}) - 9'(CHROMA_OFS);
    assign w_e = $signed({1'b0, i_pix.v}) - 9'(CHROMA_OFS);

    assign n_c  = PROD_W'(w_y) * PROD_W'(COEF_Y);
    assign n_rv = PROD_W'(w_e) * PROD_W'(COEF_RV);
    assign n_gu = PROD_W'(w_d) * PROD_W'(COEF_GU);
    assign n_gv = PROD_W'(w_e) * PROD_W'(COEF_GV);
    assign n_bu = PROD_W'(w_d) * PROD_W'(COEF_BU);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c  <= n_c;
            r_rv <= n_rv;
            r_gu <= n_gu;
            r_gv <= n_gv;
            r_bu <= n_bu;
        end
    end

    assign w_r = SUM_W'(r_c) + SUM_W'(r_rv) + SUM_W'(RGB_RND);
    assign w_g = SUM_W'(r_c) - SUM_W'(r_gu) - SUM_W'(r_gv) + SUM_W'(RGB_RND);
    assign w_b = SUM_W'(r_c) + SUM_W'(r_bu) + SUM_W'(RGB_RND);

    assign o_rgb.r = clamp_shift8(w_r);
    assign o_rgb.g = clamp_shift8(w_g);
    assign o_rgb.b = clamp_shift8(w_b);

endmodule

// File: sim/tb_yuv420_quad_to_rgb.sv
// Self-checking testbench for the 4:2:0 luma quad to RGB converter.
`timescale 1ns / 1ps

module tb_yuv420_quad_to_rgb;

    import yqr_pkg::*;

    localparam int PIPE_DEPTH   = 3;
    localparam int RANDOM_QUADS = 600;

    typedef struct packed {
        logic [PIX_W-1:0] luma_tl;
        logic [PIX_W-1:0] luma_tr;
        logic [PIX_W-1:0] luma_bl;
        logic [PIX_W-1:0] luma_br;
        logic [PIX_W-1:0] cb_prev;
        logic [PIX_W-1:0] cb_curr;
        logic [PIX_W-1:0] cb_next;
        logic [PIX_W-1:0] cb_post;
        logic [PIX_W-1:0] cr_prev;
        logic [PIX_W-1:0] cr_curr;
        logic [PIX_W-1:0] cr_next;
        logic [PIX_W-1:0] cr_post;
    } quad_t;

    typedef struct packed {
        t_rgb tl;
        t_rgb tr;
        t_rgb bl;
        t_rgb br;
    } pixel_quad_t;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_PERIODIC,
        STALL_HEAVY
    } stall_mode_e;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        drive_valid = 1'b0;
    quad_t       drive_quad  = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    pixel_quad_t rgb_out;

    pixel_quad_t expected_pixels[$];
    int          error_count  = 0;
    stall_mode_e stall_mode   = STALL_NONE;
    int          hold_request = 0;

    string channel_name[12] = '{
        "red_top_left", "green_top_left", "blue_top_left",
        "red_top_right", "green_top_right", "blue_top_right",
        "red_bottom_left", "green_bottom_left", "blue_bottom_left",
        "red_bottom_right", "green_bottom_right", "blue_bottom_right"
    };

    always #2 i_clk = ~i_clk;

    yuv420_quad_to_rgb dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (drive_valid),
        .o_stall             (o_stall),
        .i_luma_top_left     (drive_quad.luma_tl),
        .i_luma_top_right    (drive_quad.luma_tr),
        .i_luma_bottom_left  (drive_quad.luma_bl),
        .i_luma_bottom_right (drive_quad.luma_br),
        .i_cb_prev_row       (drive_quad.cb_prev),
        .i_cb_curr_row       (drive_quad.cb_curr),
        .i_cb_next_row       (drive_quad.cb_next),
        .i_cb_post_row       (drive_quad.cb_post),
        .i_cr_prev_row       (drive_quad.cr_prev),
        .i_cr_curr_row       (drive_quad.cr_curr),
        .i_cr_next_row       (drive_quad.cr_next),
        .i_cr_post_row       (drive_quad.cr_post),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_red_top_left      (rgb_out.tl.r),
        .o_green_top_left    (rgb_out.tl.g),
        .o_blue_top_left     (rgb_out.tl.b),
        .o_red_top_right     (rgb_out.tr.r),
        .o_green_top_right   (rgb_out.tr.g),
        .o_blue_top_right    (rgb_out.tr.b),
        .o_red_bottom_left   (rgb_out.bl.r),
        .o_green_bottom_left (rgb_out.bl.g),
        .o_blue_bottom_left  (rgb_out.bl.b),
        .o_red_bottom_right  (rgb_out.br.r),
        .o_green_bottom_right(rgb_out.br.g),
        .o_blue_bottom_right (rgb_out.br.b)
    );

    // ---------------- color math ----------------

    function automatic logic [PIX_W-1:0] sat_byte(int v);
        if (v < 0) begin
            return '0;
        end
        if (v > 255) begin
            return 8'd255;
        end
        return v[PIX_W-1:0];
    endfunction

    // Vertical chroma filter (-1,9,9,-1)/16 with rounding; >>> on int floors.
    function automatic logic [PIX_W-1:0] vert_interp(logic [PIX_W-1:0] p, logic [PIX_W-1:0] c,
                                                     logic [PIX_W-1:0] n, logic [PIX_W-1:0] q);
        int s;
        s = 9 * (int'(c) + int'(n)) - (int'(p) + int'(q)) + INTERP_RND;
        return sat_byte(s >>> 4);
    endfunction

    function automatic t_rgb yuv_pixel(logic [PIX_W-1:0] y, logic [PIX_W-1:0] u,
                                       logic [PIX_W-1:0] v);
        int   c;
        int   d;
        int   e;
        t_rgb px;
        c    = COEF_Y * (int'(y) - LUMA_OFS);
        d    = int'(u) - CHROMA_OFS;
        e    = int'(v) - CHROMA_OFS;
        px.r = sat_byte((c + COEF_RV * e + RGB_RND) >>> 8);
        px.g = sat_byte((c - COEF_GU * d - COEF_GV * e + RGB_RND) >>> 8);
        px.b = sat_byte((c + COEF_BU * d + RGB_RND) >>> 8);
        return px;
    endfunction

    function automatic pixel_quad_t predict_quad(quad_t q);
        logic [PIX_W-1:0] cb_low;
        logic [PIX_W-1:0] cr_low;
        pixel_quad_t      p;
        cb_low = vert_interp(q.cb_prev, q.cb_curr, q.cb_next, q.cb_post);
        cr_low = vert_interp(q.cr_prev, q.cr_curr, q.cr_next, q.cr_post);
        p.tl   = yuv_pixel(q.luma_tl, q.cb_curr, q.cr_curr);
        p.tr   = yuv_pixel(q.luma_tr, q.cb_curr, q.cr_curr);
        p.bl   = yuv_pixel(q.luma_bl, cb_low, cr_low);
        p.br   = yuv_pixel(q.luma_br, cb_low, cr_low);
        return p;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic quad_t make_quad(
        logic [7:0] ytl, logic [7:0] ytr, logic [7:0] ybl, logic [7:0] ybr,
        logic [7:0] up, logic [7:0] uc, logic [7:0] un, logic [7:0] upo,
        logic [7:0] vp, logic [7:0] vc, logic [7:0] vn, logic [7:0] vpo);
        return '{ytl, ytr, ybl, ybr, up, uc, un, upo, vp, vc, vn, vpo};
    endfunction

    function automatic logic [7:0] corner_byte();
        logic [7:0] picks[13] = '{0, 1, 15, 16, 17, 127, 128, 129, 234, 235, 236, 254, 255};
        return picks[$urandom_range(0, 12)];
    endfunction

    function automatic logic [7:0] near_byte(int base, int span);
        int v;
        v = base + $urandom_range(0, 2 * span) - span;
        return sat_byte(v);
    endfunction

    // Mix of uniform bytes, smooth chroma rows as in real frames, and corner values.
    function automatic quad_t random_quad();
        quad_t q;
        int    cb_base;
        int    cr_base;
        int    flavor;
        flavor = $urandom_range(0, 2);
        for (int i = 0; i < 12; i++) begin
            q[8*i +: 8] = (flavor == 2) ? corner_byte() : 8'($urandom_range(0, 255));
        end
        if (flavor == 1) begin
            cb_base   = $urandom_range(0, 255);
            cr_base   = $urandom_range(0, 255);
            q.cb_prev = near_byte(cb_base, 16);
            q.cb_curr = near_byte(cb_base, 16);
            q.cb_next = near_byte(cb_base, 16);
            q.cb_post = near_byte(cb_base, 16);
            q.cr_prev = near_byte(cr_base, 16);
            q.cr_curr = near_byte(cr_base, 16);
            q.cr_next = near_byte(cr_base, 16);
            q.cr_post = near_byte(cr_base, 16);
        end
        return q;
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_quad(input quad_t q);
        drive_quad  <= q;
        drive_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        expected_pixels.push_back(predict_quad(q));
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            drive_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        int waited;
        waited = 0;
        drive_valid <= 1'b0;
        while (expected_pixels.size() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    // ---------------- receiver and result checking ----------------

    always @(posedge i_clk) begin
        static int hold_left   = 0;
        static int stall_phase = 0;
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        stall_phase = (stall_phase + 1) % 7;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            case (stall_mode)
                STALL_NONE: begin
                    i_stall <= 1'b0;
                end
                STALL_LIGHT: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                STALL_PERIODIC: begin
                    i_stall <= (stall_phase < 3);
                end
                default: begin
                    i_stall <= ($urandom_range(0, 9) < 7);
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        pixel_quad_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result transaction, got %h", $time, rgb_out);
            end else begin
                want = expected_pixels.pop_front();
                for (int i = 0; i < 12; i++) begin
                    if (rgb_out[95-8*i -: 8] !== want[95-8*i -: 8]) begin
                        error_count++;
                        $display("%0t: %s expected %0d, got %0d", $time, channel_name[i],
                                 want[95-8*i -: 8], rgb_out[95-8*i -: 8]);
                    end
                end
            end
        end
    end

    // ---------------- tests ----------------

    task automatic test_corner_quads();
        quad_t corners[$];
        corners.push_back(make_quad(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        corners.push_back(make_quad(255, 255, 255, 255, 255, 255, 255, 255,
                                    255, 255, 255, 255));
        corners.push_back(make_quad(16, 16, 16, 16, 128, 128, 128, 128,
                                    128, 128, 128, 128));
        corners.push_back(make_quad(235, 235, 235, 235, 128, 128, 128, 128,
                                    128, 128, 128, 128));
        corners.push_back(make_quad(255, 255, 255, 255, 0, 0, 0, 0, 255, 255, 255, 255));
        corners.push_back(make_quad(255, 255, 255, 255, 255, 255, 255, 255, 0, 0, 0, 0));
        corners.push_back(make_quad(0, 0, 0, 0, 255, 255, 255, 255, 255, 255, 255, 255));
        // Outer taps dominate: the filtered chroma goes below zero and must clamp.
        corners.push_back(make_quad(128, 128, 128, 128, 255, 0, 0, 255, 255, 0, 0, 255));
        // Inner taps at full scale: the filtered chroma overshoots 255.
        corners.push_back(make_quad(128, 128, 128, 128, 0, 255, 255, 0, 0, 255, 255, 0));
        corners.push_back(make_quad(200, 60, 200, 60, 255, 0, 0, 255, 0, 255, 255, 0));
        // Distinct rows on each plane catch swapped taps or swapped U and V.
        corners.push_back(make_quad(90, 140, 30, 220, 10, 200, 50, 90, 240, 30, 180, 5));
        corners.push_back(make_quad(8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55,
                                    8'h55, 8'hAA, 8'h55, 8'hAA));
        corners.push_back(make_quad(8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA,
                                    8'hAA, 8'h55, 8'hAA, 8'h55));
        // Small filter sums near the rounding point, negative and positive.
        corners.push_back(make_quad(100, 100, 100, 100, 1, 0, 0, 1, 0, 1, 0, 0));
        corners.push_back(make_quad(0, 85, 170, 255, 128, 128, 128, 128,
                                    128, 128, 128, 128));
        corners.push_back(make_quad(15, 17, 254, 1, 127, 129, 126, 130, 129, 127, 130, 126));
        corners.push_back(make_quad(16, 235, 16, 235, 16, 240, 240, 16, 240, 16, 16, 240));
        stall_mode = STALL_NONE;
        foreach (corners[i]) begin
            send_quad(corners[i]);
        end
        wait_for_results();
        stall_mode = STALL_LIGHT;
        foreach (corners[i]) begin
            send_quad(corners[i]);
            idle_sender($urandom_range(0, 2));
        end
        wait_for_results();
    endtask

    // The receiver holds off long enough for every stage to fill and stall the input.
    task automatic test_output_hold();
        stall_mode   = STALL_NONE;
        hold_request = 60;
        for (int i = 0; i < 20; i++) begin
            send_quad(random_quad());
        end
        wait_for_results();
    endtask

    task automatic test_random_stream();
        int sent;
        int burst;
        sent = 0;
        while (sent < RANDOM_QUADS) begin
            stall_mode = stall_mode_e'((sent / 100) % 4);
            if (sent >= 300 && sent < 310) begin
                hold_request = 30;
            end
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && sent < RANDOM_QUADS; i++) begin
                send_quad(random_quad());
                sent++;
            end
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
        end
        wait_for_results();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_quads();
        test_output_hold();
        test_random_stream();
        if (expected_pixels.size() > 0) begin
            error_count += expected_pixels.size();
            $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("%0t: timeout", $time);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/yqr_pkg.sv
hw/rtl/yqr_interp.sv
hw/rtl/yqr_lane.sv
hw/rtl/yuv420_quad_to_rgb.sv
sim/tb_yuv420_quad_to_rgb.sv
